// ===== sv/irpd_pkg.sv =====
// Shared types, register indexes and reset values for the IR pulse frame decoder.
// No dependencies; every other file imports this package.
package irpd_pkg;

	localparam int unsigned TIME_W     = 16;
	localparam int unsigned CODE_W     = 32;
	localparam int unsigned KEY_W      = 8;
	localparam int unsigned KEY_LSB    = 8;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned PHASE_W    = 3;
	localparam int unsigned CODE_BITS_DEF = 32;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_LEADER_MARK_MIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEADER_MARK_MAX  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LEADER_SPACE_MIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LEADER_SPACE_MAX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MARK_MAX         = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SPACE_MAX        = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_THRESHOLD    = 3'd7;

	// reset values, microseconds
	localparam logic [TIME_W-1:0] RST_LEADER_MARK_MIN  = 16'd8500;
	localparam logic [TIME_W-1:0] RST_LEADER_MARK_MAX  = 16'd9500;
	localparam logic [TIME_W-1:0] RST_LEADER_SPACE_MIN = 16'd4000;
	localparam logic [TIME_W-1:0] RST_LEADER_SPACE_MAX = 16'd5000;
	localparam logic [TIME_W-1:0] RST_SHORT_MIN        = 16'd400;
	localparam logic [TIME_W-1:0] RST_MARK_MAX         = 16'd700;
	localparam logic [TIME_W-1:0] RST_SPACE_MAX        = 16'd1800;
	localparam logic [TIME_W-1:0] RST_ONE_THRESHOLD    = 16'd1000;

	// decoder phases
	localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
	localparam logic [PHASE_W-1:0] PH_LMARK  = 3'd1;
	localparam logic [PHASE_W-1:0] PH_LSPACE = 3'd2;
	localparam logic [PHASE_W-1:0] PH_BMARK  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_BSPACE = 3'd4;

	// input command codes
	localparam logic CMD_EDGE    = 1'b0;
	localparam logic CMD_TIMEOUT = 1'b1;

	typedef struct packed {
		logic [TIME_W-1:0] leader_mark_min;
		logic [TIME_W-1:0] leader_mark_max;
		logic [TIME_W-1:0] leader_space_min;
		logic [TIME_W-1:0] leader_space_max;
		logic [TIME_W-1:0] short_min;
		logic [TIME_W-1:0] mark_max;
		logic [TIME_W-1:0] space_max;
		logic [TIME_W-1:0] one_threshold;
	} irpd_cfg_t;

	typedef struct packed {
		logic              command;
		logic [TIME_W-1:0] elapsed_us;
	} irpd_item_t;

	typedef struct packed {
		logic              frame_done;
		logic [CODE_W-1:0] frame_code;
		logic [KEY_W-1:0]  key_byte;
		logic              frame_aborted;
	} irpd_result_t;

	// strict window: both bounds are outside
	function automatic logic in_window(input logic [TIME_W-1:0] v,
		input logic [TIME_W-1:0] lo, input logic [TIME_W-1:0] hi);
		return (v > lo) && (v < hi);
	endfunction

endpackage

// ===== sv/irpd_cfg.sv =====
// Timing window registers of the IR pulse frame decoder, written through a plain port.
// Depends on irpd_pkg.
module irpd_cfg import irpd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [TIME_W-1:0]    cfg_data,
	output irpd_cfg_t            cfg
);

	irpd_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.leader_mark_min  <= RST_LEADER_MARK_MIN;
			cfg_q.leader_mark_max  <= RST_LEADER_MARK_MAX;
			cfg_q.leader_space_min <= RST_LEADER_SPACE_MIN;
			cfg_q.leader_space_max <= RST_LEADER_SPACE_MAX;
			cfg_q.short_min        <= RST_SHORT_MIN;
			cfg_q.mark_max         <= RST_MARK_MAX;
			cfg_q.space_max        <= RST_SPACE_MAX;
			cfg_q.one_threshold    <= RST_ONE_THRESHOLD;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_LEADER_MARK_MIN:  cfg_q.leader_mark_min  <= cfg_data;
				CFG_LEADER_MARK_MAX:  cfg_q.leader_mark_max  <= cfg_data;
				CFG_LEADER_SPACE_MIN: cfg_q.leader_space_min <= cfg_data;
				CFG_LEADER_SPACE_MAX: cfg_q.leader_space_max <= cfg_data;
				CFG_SHORT_MIN:        cfg_q.short_min        <= cfg_data;
				CFG_MARK_MAX:         cfg_q.mark_max         <= cfg_data;
				CFG_SPACE_MAX:        cfg_q.space_max        <= cfg_data;
				CFG_ONE_THRESHOLD:    cfg_q.one_threshold    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/irpd_core.sv =====
// Frame decoding state (phase, bit count, shift register) and the per-edge step logic.
// Depends on irpd_pkg; driven by the top level's input stage.
module irpd_core import irpd_pkg::*; #(
	parameter int unsigned CODE_BITS = CODE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step_en,
	input  irpd_item_t   item,
	input  irpd_cfg_t    cfg,
	output irpd_result_t result
);

	localparam int unsigned CNT_W = $clog2(CODE_BITS + 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CODE_BITS - 1);

	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [CODE_W-1:0]  shift_q, shift_d;
	logic               done, aborted;
	logic               bit_val;

	assign bit_val = item.elapsed_us > cfg.one_threshold;

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		shift_d = shift_q;
		done    = 1'b0;
		aborted = 1'b0;
		if (item.command == CMD_TIMEOUT) begin
			aborted = (phase_q != PH_IDLE) && (phase_q <= PH_BSPACE);
			phase_d = PH_IDLE;
		end else begin
			unique case (phase_q)
				PH_LMARK: begin
					aborted = !in_window(item.elapsed_us, cfg.leader_mark_min,
						cfg.leader_mark_max);
					phase_d = aborted ? PH_IDLE : PH_LSPACE;
				end
				PH_LSPACE: begin
					aborted = !in_window(item.elapsed_us, cfg.leader_space_min,
						cfg.leader_space_max);
					phase_d = aborted ? PH_IDLE : PH_BMARK;
				end
				PH_BMARK: begin
					aborted = !in_window(item.elapsed_us, cfg.short_min, cfg.mark_max);
					phase_d = aborted ? PH_IDLE : PH_BSPACE;
				end
				PH_BSPACE: begin
					if (in_window(item.elapsed_us, cfg.short_min, cfg.space_max)) begin
						shift_d = {shift_q[CODE_W-2:0], bit_val};
						count_d = count_q + 1'b1;
						done    = (count_q >= CNT_LAST);
						phase_d = done ? PH_IDLE : PH_BMARK;
					end else begin
						aborted = 1'b1;
						phase_d = PH_IDLE;
					end
				end
				default: begin
					// idle, and any stray phase code: the edge only opens a frame
					count_d = '0;
					shift_d = '0;
					phase_d = PH_LMARK;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
			shift_q <= '0;
		end else if (step_en) begin
			phase_q <= phase_d;
			count_q <= count_d;
			shift_q <= shift_d;
		end
	end

	assign result.frame_done    = done;
	assign result.frame_code    = done ? shift_d : '0;
	assign result.key_byte      = done ? shift_d[KEY_LSB +: KEY_W] : '0;
	assign result.frame_aborted = aborted;

endmodule

// ===== sv/ir_pulse_frame_decoder_unit.sv =====
// IR pulse frame decoder, top level: input stage, decoder core, result register.
// Depends on irpd_pkg, irpd_cfg and irpd_core.
//
// Decodes NEC-style remote frames from line-edge events. Each request on the
// slave channel is one event: tuser is the command (edge or timer overflow),
// tdata the microseconds since the previous edge. Every request gives exactly
// one result on the master channel: tuser flags a completed frame or an abort,
// tdata carries the 32-bit code and its key byte (both zero unless complete).
// Write window registers (cfg_we/cfg_addr/cfg_data) only while idle; unchecked.
//
// A request waits in the input register until the result register is free;
// then the compare/shift step loads the result register for the master side.
// Throughput is one request per cycle while results are taken; the step is a
// handful of 16-bit compares and a one-bit shift. A stalled master side holds
// the result register; the input register fills and then s_tready drops until
// the result is taken. Reset returns the decoder to idle, clears both stages
// and reloads the default windows.
module ir_pulse_frame_decoder_unit import irpd_pkg::*; #(
	parameter int unsigned CODE_BITS = CODE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,   // [15:0] elapsed_us
	input  logic                 s_tuser,   // [0] command
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [39:0]          m_tdata,   // [31:0] frame_code, [39:32] key_byte
	output logic [1:0]           m_tuser,   // [0] frame_done, [1] frame_aborted
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [TIME_W-1:0]    cfg_data
);

	irpd_cfg_t    cfg;
	irpd_item_t   item_s1;
	logic         valid_s1;
	irpd_result_t res_d, res_s2;
	logic         valid_s2;
	logic         s_accept, out_free, advance;

	assign out_free = !valid_s2 || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || advance;
	assign s_accept = s_tvalid && s_tready;

	irpd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	irpd_core #(.CODE_BITS(CODE_BITS)) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= s_accept || (valid_s1 && !advance);
			valid_s2 <= advance || (valid_s2 && !m_tready);
		end
	end

	// payload registers: input loads on an accepted request, result on advance; both hold otherwise
	always_ff @(posedge clk) begin
		if (s_accept) begin
			item_s1.command    <= s_tuser;
			item_s1.elapsed_us <= s_tdata;
		end
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.key_byte, res_s2.frame_code};
	assign m_tuser  = {res_s2.frame_aborted, res_s2.frame_done};

	a_done_xor_abort: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("frame reported both done and aborted");

	a_code_zero_unless_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
		else $error("code reported without a completed frame");

	a_key_matches_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[39:32] == m_tdata[15:8]))
		else $error("key byte differs from code bits 15..8");

	a_s1_held_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> (valid_s1 && $stable(item_s1)))
		else $error("input stage lost its request while the output was stalled");

endmodule
